/* rtl/core/psc_pkg.sv */
// shared types and fixed-point constants of the pi speed controller
package psc_pkg;

    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;

    localparam int KP_W    = 20;
    localparam int KI_W    = 20;
    localparam int STEP_W  = 32;
    localparam int LIMIT_W = 12;
    localparam int TORQUE_W = 12;
    localparam int DAC_W   = 12;

    localparam logic [KP_W-1:0]    KP_RESET    = 20'd3277;
    localparam logic [KI_W-1:0]    KI_RESET    = 20'd3277;
    localparam logic [STEP_W-1:0]  STEP_RESET  = 32'd85899;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 12'd2000;

    // shared multiplier: signed a by signed b
    localparam int MUL_A_W = 33;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;

    // error q12.8, integral q12.24, duty q24
    localparam int ERR_W      = 21;
    localparam int ERR_SH     = 8;
    localparam int ERR_MAX    = 2**20 - 1;
    localparam int ERR_MIN    = -(2**20);
    localparam int SUM_W      = ERR_W + 1;
    localparam int INT_W      = 37;
    localparam int INT_SPLIT  = 18;
    localparam int INTS_W     = 39;
    localparam int STEP_SH    = 17;
    localparam int STEPV_W    = PROD_W - STEP_SH;
    localparam int KIACC_W    = 58;
    localparam int KI_SH      = 16;
    localparam int DUTY_W     = 43;
    localparam int DUTYX_SH   = 14;
    localparam int DUTYX_W    = 17;
    localparam int DAC_SHIFT  = 26;

    localparam logic [14:0] SCALE_Q16 = 15'd19202;
    // ceil(2^26/25): duty/409600 = (duty>>14)/25
    localparam logic [21:0] DAC_RECIP = 22'd2684355;
    localparam logic signed [DUTY_W-1:0] DUTY_FULL = 43'sd1677721600;

    typedef enum logic [1:0] {
        REG_KP    = 2'd0,
        REG_KI    = 2'd1,
        REG_STEP  = 2'd2,
        REG_LIMIT = 2'd3
    } reg_idx_t;

    typedef struct packed {
        logic [KP_W-1:0]    kp;
        logic [KI_W-1:0]    ki;
        logic [STEP_W-1:0]  int_step;
        logic [LIMIT_W-1:0] int_limit;
    } cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_ERR_SAT,
        BK_STEP_MUL,
        BK_INTEG,
        BK_KI_HI,
        BK_KI_LO,
        BK_KI_SUM,
        BK_DUTY,
        BK_DAC_MUL,
        BK_DONE
    } bk_state_t;

    typedef enum logic [2:0] {
        MS_NONE,
        MS_ERR,
        MS_STEP,
        MS_KP,
        MS_KI_HI,
        MS_KI_LO,
        MS_DAC
    } mul_sel_t;

endpackage

/* rtl/core/psc_regs.sv */
// apb configuration registers of the pi speed controller
module psc_regs (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [psc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output psc_pkg::cfg_t                    cfg
);
    import psc_pkg::*;

    cfg_t     cfg_reg;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign cfg    = cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.kp        <= KP_RESET;
            cfg_reg.ki        <= KI_RESET;
            cfg_reg.int_step  <= STEP_RESET;
            cfg_reg.int_limit <= LIMIT_RESET;
        end
        else if (wr_en)
        begin
            unique case (idx)
                REG_KP:    cfg_reg.kp        <= pwdata[KP_W-1:0];
                REG_KI:    cfg_reg.ki        <= pwdata[KI_W-1:0];
                REG_STEP:  cfg_reg.int_step  <= pwdata[STEP_W-1:0];
                REG_LIMIT: cfg_reg.int_limit <= pwdata[LIMIT_W-1:0];
                default:   cfg_reg.kp        <= cfg_reg.kp;
            endcase
        end
    end

    always_comb
    begin
        unique case (idx)
            REG_KP:    prdata = APB_DATA_W'(cfg_reg.kp);
            REG_KI:    prdata = APB_DATA_W'(cfg_reg.ki);
            REG_STEP:  prdata = APB_DATA_W'(cfg_reg.int_step);
            REG_LIMIT: prdata = APB_DATA_W'(cfg_reg.int_limit);
            default:   prdata = '0;
        endcase
    end

endmodule

/* rtl/core/psc_front.sv */
// input side: arming on the pwm pin and forwarding of armed samples
module psc_front #(
    parameter int ADC_BITS = 12,
    parameter int IN_W     = 40,
    parameter int Q_W      = 25
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            s_tvalid,
    output logic            s_tready,
    input  logic [IN_W-1:0] s_tdata,
    input  logic            s_tuser,
    input  logic            q_full,
    output logic            q_push,
    output logic [Q_W-1:0]  q_data
);
    import psc_pkg::*;

    localparam int DIFF_W = ADC_BITS + 1;

    logic                     saw_low_reg, saw_low_next;
    logic                     armed_reg, armed_next;
    logic                     take;
    logic [ADC_BITS-1:0]      speed, ref_c;
    logic [TORQUE_W-1:0]      torque;
    logic signed [DIFF_W-1:0] diff;

    assign speed  = s_tdata[ADC_BITS-1:0];
    assign ref_c  = s_tdata[2*ADC_BITS-1:ADC_BITS];
    assign torque = s_tdata[2*ADC_BITS+TORQUE_W-1:2*ADC_BITS];
    assign diff   = $signed({1'b0, ref_c}) - $signed({1'b0, speed});

    assign s_tready = !q_full;
    assign take     = s_tvalid && s_tready;
    // the item that arms is consumed by arming
    assign q_push   = take && armed_reg;
    assign q_data   = {torque, diff};

    always_comb
    begin
        saw_low_next = saw_low_reg;
        armed_next   = armed_reg;
        if (take && !armed_reg)
        begin
            if (saw_low_reg)
                armed_next = s_tuser;
            else
                saw_low_next = !s_tuser;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            saw_low_reg <= 1'b0;
            armed_reg   <= 1'b0;
        end
        else
        begin
            saw_low_reg <= saw_low_next;
            armed_reg   <= armed_next;
        end
    end

    a_push_armed: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> armed_reg)
        else $error("sample queued before arming");

    a_armed_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        !$fell(armed_reg))
        else $error("armed dropped without reset");

endmodule

/* rtl/core/psc_queue.sv */
// short queue of armed samples between front and back
module psc_queue #(
    parameter int DATA_W = 25,
    parameter int DEPTH  = 2
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  logic [DATA_W-1:0] push_data,
    input  logic              pop,
    output logic [DATA_W-1:0] pop_data,
    output logic              full,
    output logic              empty
);
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full))
        else $error("push into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(pop && empty))
        else $error("pop from empty queue");

endmodule

/* rtl/core/psc_back.sv */
// back side: pi arithmetic on one shared multiplier and the result register
module psc_back #(
    parameter int ADC_BITS = 12,
    parameter int Q_W      = 25
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  psc_pkg::cfg_t                 cfg,
    input  logic                          q_empty,
    input  logic [Q_W-1:0]                q_data,
    output logic                          q_pop,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [psc_pkg::DAC_W-1:0]     duty_dac,
    output logic [psc_pkg::TORQUE_W-1:0]  torque_dac,
    output logic                          duty_clamped
);
    import psc_pkg::*;

    localparam int DIFF_W = ADC_BITS + 1;
    localparam int ERRP_W = PROD_W - ERR_SH;
    localparam logic signed [ERRP_W-1:0] ERR_HI = ERRP_W'(ERR_MAX);
    localparam logic signed [ERRP_W-1:0] ERR_LO = ERRP_W'(ERR_MIN);

    bk_state_t state_reg, state_next;
    mul_sel_t  mul_sel;
    logic      out_load;

    logic signed [MUL_A_W-1:0] mul_a;
    logic signed [MUL_B_W-1:0] mul_b;
    logic signed [PROD_W-1:0]  prod_reg;

    logic signed [DIFF_W-1:0]  head_diff;
    logic [TORQUE_W-1:0]       head_torque;

    logic [TORQUE_W-1:0]       torque_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic signed [ERR_W-1:0]   prev_error_reg;
    logic signed [SUM_W-1:0]   sum_reg;
    logic signed [INT_W-1:0]   integral_reg;
    logic signed [DUTY_W-1:0]  acc_reg;
    logic signed [KIACC_W-1:0] kiacc_reg;
    logic [DUTYX_W-1:0]        duty_x_reg;
    logic                      clamped_reg;

    logic                      m_tvalid_reg;
    logic [DAC_W-1:0]          duty_dac_reg;
    logic [TORQUE_W-1:0]       torque_dac_reg;
    logic                      duty_clamped_reg;

    logic signed [ERRP_W-1:0]  err_wide;
    logic signed [ERR_W-1:0]   err_sat;
    logic signed [STEPV_W-1:0] step_val;
    logic signed [INTS_W-1:0]  lim, integ_sum, integ_clamp;
    logic signed [DUTY_W-1:0]  duty, duty_c;
    logic                      duty_hit;
    logic [DAC_W:0]            dac_q;
    logic [DAC_W-1:0]          dac_val;

    assign head_diff   = $signed(q_data[DIFF_W-1:0]);
    assign head_torque = q_data[DIFF_W+TORQUE_W-1:DIFF_W];

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            BK_IDLE:     if (!q_empty) state_next = BK_ERR_SAT;
            BK_ERR_SAT:  state_next = BK_STEP_MUL;
            BK_STEP_MUL: state_next = BK_INTEG;
            BK_INTEG:    state_next = BK_KI_HI;
            BK_KI_HI:    state_next = BK_KI_LO;
            BK_KI_LO:    state_next = BK_KI_SUM;
            BK_KI_SUM:   state_next = BK_DUTY;
            BK_DUTY:     state_next = BK_DAC_MUL;
            BK_DAC_MUL:  state_next = BK_DONE;
            BK_DONE:     if (!m_tvalid_reg || m_tready) state_next = BK_IDLE;
            default:     state_next = BK_IDLE;
        endcase
    end

    // control outputs
    always_comb
    begin
        q_pop    = 1'b0;
        out_load = 1'b0;
        mul_sel  = MS_NONE;
        unique case (state_reg)
            BK_IDLE:
            begin
                q_pop   = !q_empty;
                mul_sel = MS_ERR;
            end
            BK_STEP_MUL: mul_sel = MS_STEP;
            BK_INTEG:    mul_sel = MS_KP;
            BK_KI_HI:    mul_sel = MS_KI_HI;
            BK_KI_LO:    mul_sel = MS_KI_LO;
            BK_DAC_MUL:  mul_sel = MS_DAC;
            BK_DONE:     out_load = !m_tvalid_reg || m_tready;
            default:     mul_sel = MS_NONE;
        endcase
    end

    // shared multiplier operands
    always_comb
    begin
        unique case (mul_sel)
            MS_ERR:
            begin
                mul_a = MUL_A_W'(head_diff);
                mul_b = $signed(MUL_B_W'(SCALE_Q16));
            end
            MS_STEP:
            begin
                mul_a = $signed({1'b0, cfg.int_step});
                mul_b = MUL_B_W'(sum_reg);
            end
            MS_KP:
            begin
                mul_a = $signed(MUL_A_W'(cfg.kp));
                mul_b = MUL_B_W'(err_reg);
            end
            MS_KI_HI:
            begin
                mul_a = MUL_A_W'($signed(integral_reg[INT_W-1:INT_SPLIT]));
                mul_b = $signed(MUL_B_W'(cfg.ki));
            end
            MS_KI_LO:
            begin
                mul_a = $signed(MUL_A_W'(integral_reg[INT_SPLIT-1:0]));
                mul_b = $signed(MUL_B_W'(cfg.ki));
            end
            MS_DAC:
            begin
                mul_a = $signed(MUL_A_W'(DAC_RECIP));
                mul_b = $signed(MUL_B_W'(duty_x_reg));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // datapath arithmetic around the product register
    always_comb
    begin
        err_wide = prod_reg[PROD_W-1:ERR_SH];
        if (err_wide > ERR_HI)
            err_sat = ERR_HI[ERR_W-1:0];
        else if (err_wide < ERR_LO)
            err_sat = ERR_LO[ERR_W-1:0];
        else
            err_sat = err_wide[ERR_W-1:0];

        step_val  = prod_reg[PROD_W-1:STEP_SH];
        lim       = $signed({3'b000, cfg.int_limit, 24'd0});
        integ_sum = INTS_W'(integral_reg) + INTS_W'(step_val);
        if (integ_sum > lim)
            integ_clamp = lim;
        else if (integ_sum < -lim)
            integ_clamp = -lim;
        else
            integ_clamp = integ_sum;

        duty     = acc_reg + DUTY_W'($signed(kiacc_reg[KIACC_W-1:KI_SH]));
        duty_hit = 1'b0;
        if (duty > DUTY_FULL)
        begin
            duty_c   = DUTY_FULL;
            duty_hit = 1'b1;
        end
        else if (duty < 0)
        begin
            duty_c   = '0;
            duty_hit = 1'b1;
        end
        else
            duty_c = duty;

        // quotient is at most 4096 here
        dac_q   = prod_reg[DAC_SHIFT+DAC_W:DAC_SHIFT];
        dac_val = dac_q[DAC_W] ? {DAC_W{1'b1}} : dac_q[DAC_W-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= BK_IDLE;
            prev_error_reg <= '0;
            integral_reg   <= '0;
            m_tvalid_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_STEP_MUL)
                prev_error_reg <= err_reg;
            if (state_reg == BK_INTEG)
                integral_reg <= integ_clamp[INT_W-1:0];
            if (out_load)
                m_tvalid_reg <= 1'b1;
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        // product holds between uses, so the dac quotient survives a stalled done step
        if (mul_sel != MS_NONE)
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        if (q_pop)
            torque_reg <= head_torque;
        if (state_reg == BK_ERR_SAT)
        begin
            err_reg <= err_sat;
            sum_reg <= SUM_W'(prev_error_reg) + SUM_W'(err_sat);
        end
        if (state_reg == BK_KI_HI)
            acc_reg <= prod_reg[DUTY_W-1:0];
        if (state_reg == BK_KI_LO)
            kiacc_reg <= KIACC_W'(prod_reg) <<< INT_SPLIT;
        if (state_reg == BK_KI_SUM)
            kiacc_reg <= kiacc_reg + KIACC_W'(prod_reg);
        if (state_reg == BK_DUTY)
        begin
            duty_x_reg  <= duty_c[DUTYX_SH+DUTYX_W-1:DUTYX_SH];
            clamped_reg <= duty_hit;
        end
        if (out_load)
        begin
            duty_dac_reg     <= dac_val;
            torque_dac_reg   <= torque_reg;
            duty_clamped_reg <= clamped_reg;
        end
    end

    assign m_tvalid     = m_tvalid_reg;
    assign duty_dac     = duty_dac_reg;
    assign torque_dac   = torque_dac_reg;
    assign duty_clamped = duty_clamped_reg;

    a_load_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid_reg) |-> $past(state_reg == BK_DONE))
        else $error("result word raised outside the done step");

endmodule

/* rtl/core/pi_speed_controller_duty.sv */
// top level of the pi speed controller producing a duty dac code
//
//  channel  dir  handshake                 contents
//  s_*      in   s_tvalid / s_tready       sample word: speed, reference, torque codes, pin
//  m_*      out  m_tvalid / m_tready       result word: duty and torque dac codes, clamp flag
//  apb      in   psel & penable & pwrite   kp, ki, int_step, int_limit at 0x0/0x4/0x8/0xc
//
// an armed sample runs through the back end states before the next is popped; the one
// 33x22 multiplier is used six times per sample. samples before arming are not queued.
// reset clears arming state, error history and integral, and loads register defaults.
// a two-word queue sits between input and arithmetic, so the input takes words until
// the queue is full while a result waits in the output register for m_tready.
module pi_speed_controller_duty #(
    parameter int ADC_BITS = 12
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // speed_code, ref_code, torque_code, zero pad (from bit 0)
    input  logic [((2*ADC_BITS+12+7)/8)*8-1:0] s_tdata,
    // pwm_pin
    input  logic                             s_tuser,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // duty_dac, torque_dac (from bit 0)
    output logic [23:0]                      m_tdata,
    // duty_clamped
    output logic                             m_tuser,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [psc_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [psc_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [psc_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready
);
    import psc_pkg::*;

    localparam int IN_W  = ((2*ADC_BITS + TORQUE_W + 7) / 8) * 8;
    localparam int Q_W   = ADC_BITS + 1 + TORQUE_W;

    cfg_t             cfg;
    logic             q_push, q_pop, q_full, q_empty;
    logic [Q_W-1:0]   q_in, q_out;
    logic [DAC_W-1:0] duty_dac;
    logic [TORQUE_W-1:0] torque_dac;

    psc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    psc_front #(
        .ADC_BITS (ADC_BITS),
        .IN_W     (IN_W),
        .Q_W      (Q_W)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_data   (q_in)
    );

    psc_queue #(
        .DATA_W (Q_W),
        .DEPTH  (2)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_in),
        .pop       (q_pop),
        .pop_data  (q_out),
        .full      (q_full),
        .empty     (q_empty)
    );

    psc_back #(
        .ADC_BITS (ADC_BITS),
        .Q_W      (Q_W)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .q_empty      (q_empty),
        .q_data       (q_out),
        .q_pop        (q_pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .duty_dac     (duty_dac),
        .torque_dac   (torque_dac),
        .duty_clamped (m_tuser)
    );

    assign m_tdata = {torque_dac, duty_dac};

endmodule

/* test/pi_speed_controller_duty_checker.sv */
// checker for the pi speed controller: duty prediction from observed words and result compare
module pi_speed_controller_duty_checker
    import psc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    // speed_code, ref_code, torque_code, zero pad (from bit 0)
    input  logic [39:0]           s_tdata,
    // pwm_pin
    input  logic                  s_tuser,
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    // duty_dac, torque_dac (from bit 0)
    input  logic [23:0]           m_tdata,
    // duty_clamped
    input  logic                  m_tuser,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    fail_count,
    output int                    pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint RAD_PER_CODE_Q16 = 19202;
    localparam longint ERR_HI           = (longint'(1) << 20) - 1;
    localparam longint ERR_LO           = -(longint'(1) << 20);
    localparam longint DUTY_TOP         = longint'(100) << 24;
    localparam longint DAC_STEP         = 409600;
    localparam longint DAC_TOP          = 4095;
    localparam int     REPORT_LIMIT     = 10;

    typedef struct packed {
        logic [DAC_W-1:0]    duty_dac;
        logic [TORQUE_W-1:0] torque_dac;
        logic                clamped;
    } duty_word_t;

    // controller registers as last written over apb
    logic [KP_W-1:0]    gain_p;
    logic [KI_W-1:0]    gain_i;
    logic [STEP_W-1:0]  step_len;
    logic [LIMIT_W-1:0] integ_limit;

    // controller state
    logic signed [ERR_W-1:0] last_err;
    logic signed [INT_W-1:0] integ_acc;
    logic                    pin_was_low;
    logic                    running;

    duty_word_t pending_duty_words[$];

    // advances the controller by one sample; returns 1 when a duty word comes out
    function automatic bit duty_from_sample(input logic [11:0] spd, input logic [11:0] rf,
                                            input logic [11:0] trq, input logic pin,
                                            output duty_word_t word);
        longint err;
        longint step;
        longint lim;
        longint acc;
        longint duty;
        longint dac;
        bit     clip;
        word = '0;
        clip = 1'b0;
        if (!running) begin
            if (pin_was_low)
                running = pin;
            else
                pin_was_low = !pin;
            return 1'b0;
        end
        err = ((longint'(rf) - longint'(spd)) * RAD_PER_CODE_Q16) >>> 8;
        if (err > ERR_HI) err = ERR_HI;
        if (err < ERR_LO) err = ERR_LO;

        // trapezoid: mean of both errors times step, q12.8 * q0.32 / 2^17 -> q24
        step = ((longint'(last_err) + err) * longint'(step_len)) >>> 17;
        lim  = longint'(integ_limit) <<< 24;
        acc  = longint'(integ_acc) + step;
        if (acc > lim) acc = lim;
        if (acc < -lim) acc = -lim;

        duty = longint'(gain_p) * err + ((longint'(gain_i) * acc) >>> 16);
        if (duty > DUTY_TOP) begin
            duty = DUTY_TOP;
            clip = 1'b1;
        end
        if (duty < 0) begin
            duty = 0;
            clip = 1'b1;
        end

        integ_acc = acc[INT_W-1:0];
        last_err  = err[ERR_W-1:0];

        dac = duty / DAC_STEP;
        if (dac > DAC_TOP) dac = DAC_TOP;
        word.duty_dac   = dac[DAC_W-1:0];
        word.torque_dac = trq;
        word.clamped    = clip;
        return 1'b1;
    endfunction

    always @(posedge clk) begin
        duty_word_t want;
        duty_word_t got;
        if (!rst_n) begin
            gain_p      = KP_RESET;
            gain_i      = KI_RESET;
            step_len    = STEP_RESET;
            integ_limit = LIMIT_RESET;
            last_err    = '0;
            integ_acc   = '0;
            pin_was_low = 1'b0;
            running     = 1'b0;
            pending_duty_words.delete();
            fail_count  = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (reg_idx_t'(paddr[3:2]))
                    REG_KP:    gain_p      = pwdata[KP_W-1:0];
                    REG_KI:    gain_i      = pwdata[KI_W-1:0];
                    REG_STEP:  step_len    = pwdata[STEP_W-1:0];
                    REG_LIMIT: integ_limit = pwdata[LIMIT_W-1:0];
                    default: ;
                endcase
            end

            // results first: a word accepted now stems from an earlier sample
            if (m_tvalid && m_tready) begin
                got.duty_dac   = m_tdata[11:0];
                got.torque_dac = m_tdata[23:12];
                got.clamped    = m_tuser;
                if (pending_duty_words.size() == 0) begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("%0t: duty word with none expected: duty %0d torque %0d clamp %0d",
                                 $realtime, got.duty_dac, got.torque_dac, got.clamped);
                end else begin
                    want = pending_duty_words.pop_front();
                    if (got.duty_dac !== want.duty_dac || got.torque_dac !== want.torque_dac ||
                        got.clamped !== want.clamped) begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display({"%0t: duty word mismatch: expected duty %0d torque %0d ",
                                      "clamp %0d, got duty %0d torque %0d clamp %0d"},
                                     $realtime, want.duty_dac, want.torque_dac, want.clamped,
                                     got.duty_dac, got.torque_dac, got.clamped);
                    end
                end
            end

            if (s_tvalid && s_tready) begin
                if (duty_from_sample(s_tdata[11:0], s_tdata[23:12], s_tdata[35:24], s_tuser,
                                     want))
                    pending_duty_words.push_back(want);
            end
        end
        pending = pending_duty_words.size();
    end

endmodule

/* test/pi_speed_controller_duty_tb.sv */
// testbench top for the pi speed controller: stimulus, register loads and verdict
module pi_speed_controller_duty_tb;
    import psc_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 5000;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int RAND_PHASES  = 8;
    localparam int PHASE_ITEMS  = 130;

    typedef enum int {
        READY_ALWAYS,
        READY_HALF,
        READY_SPARSE
    } ready_mode_t;

    logic                  clk;
    logic                  rst_n;
    logic                  s_tvalid;
    logic                  s_tready;
    // speed_code, ref_code, torque_code, zero pad (from bit 0)
    logic [39:0]           s_tdata;
    // pwm_pin
    logic                  s_tuser;
    logic                  m_tvalid;
    logic                  m_tready;
    // duty_dac, torque_dac (from bit 0)
    logic [23:0]           m_tdata;
    // duty_clamped
    logic                  m_tuser;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int fail_count;
    int pending;
    int burst_left;
    int quiet_cycles;
    bit hold_req;
    bit hold_done;

    pi_speed_controller_duty dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    pi_speed_controller_duty_checker u_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tuser    (s_tuser),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .pready     (pready),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // offers one sample word; the sender runs in bursts with random gaps
    task automatic offer_sample(input logic [11:0] spd, input logic [11:0] rf,
                                input logic [11:0] trq, input logic pin);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_tdata  <= {4'b0, trq, rf, spd};
        s_tuser  <= pin;
        s_tvalid <= 1'b1;
        do @(posedge clk); while (!s_tready);
    endtask

    // setup then access; psel stays up so writes can follow back to back
    task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
    endtask

    task automatic load_gains(input logic [31:0] kp, input logic [31:0] ki,
                              input logic [31:0] step, input logic [31:0] lim);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_STEP, step);
        write_reg(REG_LIMIT, lim);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // stop offering, let every expected word arrive, then give the back end time
    task automatic settle();
        s_tvalid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    function automatic logic [31:0] pick_gain(input int w);
        logic [31:0] mask;
        mask = (w >= 32) ? 32'hFFFF_FFFF : ((32'd1 << w) - 32'd1);
        case ($urandom_range(0, 5))
            0:       return 32'd0;
            1:       return mask;
            2, 3:    return $urandom & (mask >> 4);
            default: return $urandom & mask;
        endcase
    endfunction

    // receiver: ready pattern that changes mode now and then, plus one long hold-off
    initial begin
        ready_mode_t mode;
        int          mode_left;
        mode_left = 0;
        mode      = READY_ALWAYS;
        m_tready <= 1'b0;
        @(posedge clk);
        forever begin
            if (hold_req && !hold_done) begin
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end else begin
                if (mode_left == 0) begin
                    mode      = ready_mode_t'($urandom_range(0, 2));
                    mode_left = $urandom_range(10, 150);
                end
                mode_left--;
                case (mode)
                    READY_ALWAYS: m_tready <= 1'b1;
                    READY_HALF:   m_tready <= 1'($urandom_range(0, 1));
                    default:      m_tready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge clk);
            end
        end
    end

    // watchdog: cycles in which no word and no register write is taken
    always @(posedge clk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable && pready))
            quiet_cycles = 0;
        else begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT) begin
                $display("pi_speed_controller_duty_tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        int spd;
        int rf;
        burst_left   = 0;
        quiet_cycles = 0;
        hold_req     = 1'b0;
        hold_done    = 1'b0;
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        s_tuser  <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;

        // arming: high pin ignored, low seen, low again keeps waiting, high arms
        offer_sample(12'd4095, 12'd0, 12'd4095, 1'b1);
        offer_sample(12'd0, 12'd4095, 12'd0, 1'b0);
        offer_sample(12'd4095, 12'd4095, 12'd4095, 1'b0);
        offer_sample(12'd0, 12'd0, 12'd0, 1'b1);
        // zero error with empty integral gives duty of exactly zero, unflagged
        offer_sample(12'd2048, 12'd2048, 12'd2048, 1'b1);
        offer_sample(12'd0, 12'd4095, 12'd4095, 1'b0);
        offer_sample(12'd4095, 12'd0, 12'd0, 1'b1);
        offer_sample(12'd2000, 12'd2100, 12'd1234, 1'b0);
        offer_sample(12'd2100, 12'd2000, 12'd2222, 1'b1);

        // pure proportional at full gain, integral pinned at zero
        settle();
        load_gains(32'hF_FFFF, 32'd0, 32'd0, 32'd0);
        offer_sample(12'd2048, 12'd2049, 12'd100, 1'b0);
        offer_sample(12'd2048, 12'd2048, 12'd200, 1'b1);
        offer_sample(12'd2049, 12'd2048, 12'd300, 1'b0);
        offer_sample(12'd0, 12'd4095, 12'd400, 1'b1);

        // integral driven to +1600, then zero error: ki*1600 lands exactly on 100 percent
        settle();
        load_gains(32'd0, 32'd4096, 32'hFFFF_FFFF, 32'd1600);
        offer_sample(12'd0, 12'd4095, 12'd11, 1'b0);
        offer_sample(12'd0, 12'd4095, 12'd22, 1'b1);
        offer_sample(12'd0, 12'd4095, 12'd33, 1'b0);
        offer_sample(12'd1000, 12'd1000, 12'd44, 1'b1);
        offer_sample(12'd4095, 12'd0, 12'd55, 1'b0);
        offer_sample(12'd4095, 12'd0, 12'd66, 1'b1);

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            settle();
            if (ph == 0)
                load_gains(32'hF_FFFF, 32'hF_FFFF, 32'hFFFF_FFFF, 32'hFFF);
            else if (ph == 1)
                load_gains(32'(KP_RESET), 32'(KI_RESET), 32'(STEP_RESET), 32'(LIMIT_RESET));
            else
                load_gains(pick_gain(KP_W), pick_gain(KI_W), pick_gain(STEP_W),
                           pick_gain(LIMIT_W));
            if (ph == 2)
                hold_req = 1'b1;
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                spd = $urandom_range(0, 4095);
                // half the samples sit near the setpoint, within 64 codes of the speed
                if ($urandom_range(0, 1) == 1)
                    rf = $urandom_range(0, 4095);
                else begin
                    rf = spd + $urandom_range(0, 128) - 64;
                    if (rf < 0) rf = 0;
                    if (rf > 4095) rf = 4095;
                end
                offer_sample(12'(spd), 12'(rf), 12'($urandom_range(0, 4095)),
                             1'($urandom_range(0, 1)));
            end
        end

        settle();
        if (fail_count == 0 && pending == 0)
            $display("pi_speed_controller_duty_tb: PASS");
        else
            $display("pi_speed_controller_duty_tb: FAIL");
        $finish;
    end

endmodule

/* files.f */
rtl/core/psc_pkg.sv
rtl/core/psc_regs.sv
rtl/core/psc_front.sv
rtl/core/psc_queue.sv
rtl/core/psc_back.sv
rtl/core/pi_speed_controller_duty.sv
test/pi_speed_controller_duty_checker.sv
test/pi_speed_controller_duty_tb.sv
